[hw/rtl/icnsrle24_pkg.sv]
// shared types and constants for the icns rle24 channel encoder
// used by icnsrle24_ctrl, icnsrle24_dpath and icns_rle24_channel_encoder_core
`default_nettype none

package icnsrle24_pkg;

   localparam int RUN_DEPTH = 130;
   localparam int BUF_AW    = $clog2(RUN_DEPTH);
   localparam int LEN_W     = 8;
   localparam int LIT_MAX   = 128;
   localparam int REP_MAX   = 130;
   localparam int REP_BIAS  = 125;

   typedef struct packed {
      logic [7:0] channel_byte;
      logic       end_of_channel;
   } req_type;

   typedef struct packed {
      logic [63:0] code_bytes;
      logic [3:0]  byte_count;
      logic        last_word;
      logic        channel_done;
   } rsp_type;

   // where the next code byte comes from
   typedef enum logic [2:0] {
      SRC_HDR1  = 3'd0,
      SRC_HDR2  = 3'd1,
      SRC_MEM   = 3'd2,
      SRC_TAIL1 = 3'd3,
      SRC_TAIL2 = 3'd4
   } src_type;

   typedef struct packed {
      logic              take;
      logic              push;
      src_type           src;
      logic [BUF_AW-1:0] addr;
      logic              last;
      logic              commit;
   } cmd_type;

   typedef struct packed {
      logic              byte_ready;
      logic              seg1;
      logic              tail1;
      logic              eoc;
      logic [BUF_AW-1:0] cnt1;
      logic [BUF_AW-1:0] cnt2;
   } sts_type;

endpackage

`default_nettype wire

[hw/rtl/icns_rle24_channel_encoder_core.sv]
// icns rle24 encoder for one colour channel: one byte in, packed code words out
// a byte is accepted in ST_IDLE and planned in ST_DISP; its code bytes pass the byte
//   stage and the packer into the output register, eight code bytes to a word
// a byte that finishes no run gives no word; the input stalls until the sequencer is idle,
//   and buffered bytes go one a cycle through the single run buffer read port, less under output stall
// reset: synchronous, active high; clears run length, run type and all handshake state
// depends on icnsrle24_pkg, icnsrle24_ctrl, icnsrle24_dpath
`default_nettype none

module icns_rle24_channel_encoder_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire icnsrle24_pkg::req_type req_data,
   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output icnsrle24_pkg::rsp_type      rsp_data
);

   // command and status between the sequencer and the datapath
   icnsrle24_pkg::cmd_type cmd;
   icnsrle24_pkg::sts_type sts;

   // sequencer: one word at a time, walks the header, buffered bytes and tail
   // byte of up to two runs (the run closed by this byte and the end-of-channel flush)
   icnsrle24_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: run state and plan, run buffer, byte stage and eight-lane packer;
   // the output register lets the sequencer run on while a word waits
   icnsrle24_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[hw/rtl/icnsrle24_ctrl.sv]
// controller state machine: accepts words and sequences code byte emission
// depends on icnsrle24_pkg
`default_nettype none

module icnsrle24_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output icnsrle24_pkg::cmd_type      cmd,
   input  wire icnsrle24_pkg::sts_type sts
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_DISP  = 9'b000000010,
      ST_HDR1  = 9'b000000100,
      ST_BODY1 = 9'b000001000,
      ST_TAIL1 = 9'b000010000,
      ST_HDR2  = 9'b000100000,
      ST_BODY2 = 9'b001000000,
      ST_TAIL2 = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [icnsrle24_pkg::BUF_AW-1:0]   idx_ff, idx_in;
   logic                               end1, end2;

   assign end1 = (idx_ff == (sts.cnt1 - 1'b1));
   assign end2 = (idx_ff == (sts.cnt2 - 1'b1));

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cmd.take   = 1'b0;
      cmd.push   = 1'b0;
      cmd.src    = icnsrle24_pkg::SRC_HDR1;
      cmd.addr   = idx_ff;
      cmd.last   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid) begin
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            if (sts.seg1) begin
               state_in = ST_HDR1;
            end else if (sts.eoc) begin
               state_in = ST_HDR2;
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_HDR1: begin
            cmd.push = 1'b1;
            cmd.src  = icnsrle24_pkg::SRC_HDR1;
            cmd.last = (sts.cnt1 == '0) && !sts.tail1 && !sts.eoc;
            idx_in   = '0;
            if (sts.byte_ready) begin
               if (sts.cnt1 != '0) begin
                  state_in = ST_BODY1;
               end else if (sts.tail1) begin
                  state_in = ST_TAIL1;
               end else if (sts.eoc) begin
                  state_in = ST_HDR2;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_BODY1: begin
            cmd.push = 1'b1;
            cmd.src  = icnsrle24_pkg::SRC_MEM;
            cmd.last = end1 && !sts.tail1 && !sts.eoc;
            if (sts.byte_ready) begin
               idx_in = idx_ff + 1'b1;
               if (end1) begin
                  if (sts.tail1) begin
                     state_in = ST_TAIL1;
                  end else if (sts.eoc) begin
                     state_in = ST_HDR2;
                  end else begin
                     state_in = ST_FIN;
                  end
               end
            end
         end
         ST_TAIL1: begin
            cmd.push = 1'b1;
            cmd.src  = icnsrle24_pkg::SRC_TAIL1;
            cmd.last = !sts.eoc;
            if (sts.byte_ready) begin
               state_in = sts.eoc ? ST_HDR2 : ST_FIN;
            end
         end
         ST_HDR2: begin
            cmd.push = 1'b1;
            cmd.src  = icnsrle24_pkg::SRC_HDR2;
            idx_in   = '0;
            if (sts.byte_ready) begin
               state_in = (sts.cnt2 != '0) ? ST_BODY2 : ST_TAIL2;
            end
         end
         ST_BODY2: begin
            cmd.push = 1'b1;
            cmd.src  = icnsrle24_pkg::SRC_MEM;
            if (sts.byte_ready) begin
               idx_in = idx_ff + 1'b1;
               if (end2) begin
                  state_in = ST_TAIL2;
               end
            end
         end
         ST_TAIL2: begin
            cmd.push = 1'b1;
            cmd.src  = icnsrle24_pkg::SRC_TAIL2;
            cmd.last = 1'b1;
            if (sts.byte_ready) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/icnsrle24_dpath.sv]
// datapath: run state, run buffer memory, byte stage, word packer, output register
// depends on icnsrle24_pkg
`default_nettype none

module icnsrle24_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire icnsrle24_pkg::req_type req_data,
   input  wire icnsrle24_pkg::cmd_type cmd,
   output icnsrle24_pkg::sts_type      sts,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output icnsrle24_pkg::rsp_type      rsp_data
);

   localparam int AW = icnsrle24_pkg::BUF_AW;
   localparam int LW = icnsrle24_pkg::LEN_W;

   // run state
   logic [LW-1:0] len_ff;
   logic          rep_ff;
   logic [7:0]    p1_ff, p2_ff;

   // per-word plan
   logic          seg1_ff, tail1_ff, eoc_ff, wr_en_ff;
   logic [AW-1:0] cnt1_ff, cnt2_ff, wr_pos_ff;
   logic [7:0]    hdr1_ff, hdr2_ff, tail1_byte_ff, b_ff;

   logic          seg1_in, tail1_in, rep_in, match;
   logic [AW-1:0] cnt1_in, cnt2_in, wr_pos_in;
   logic [7:0]    hdr1_in, hdr2_in, b;
   logic [LW-1:0] len_in;

   // run buffer
   logic [7:0]    mem [icnsrle24_pkg::RUN_DEPTH];
   logic [7:0]    mem_rd_ff;

   // byte stage
   logic          s1_valid_ff, s1_mem_ff, s1_last_ff, s1_done_ff;
   logic [7:0]    s1_byte_ff, s1_byte_in, cur_byte;
   logic          ld, consume, completes, out_free;

   // packer
   logic [63:0]   acc_ff, merged;
   logic [2:0]    acc_cnt_ff;

   logic                   rsp_valid_ff;
   icnsrle24_pkg::rsp_type rsp_data_ff;

   assign b     = req_data.channel_byte;
   assign match = (len_ff >= LW'(2)) && (b == p1_ff) && (b == p2_ff);

   always_comb begin
      seg1_in   = 1'b0;
      tail1_in  = 1'b0;
      hdr1_in   = '0;
      cnt1_in   = '0;
      len_in    = len_ff;
      rep_in    = rep_ff;
      wr_pos_in = AW'(len_ff);
      if (len_ff == '0) begin
         len_in    = LW'(1);
         rep_in    = 1'b0;
         wr_pos_in = '0;
      end else if (len_ff == LW'(1)) begin
         len_in = LW'(2);
      end else if (len_ff == LW'(2)) begin
         rep_in = match;
         len_in = LW'(3);
      end else if (!rep_ff && (len_ff < LW'(icnsrle24_pkg::LIT_MAX))) begin
         if (match) begin
            // literal part before the last two bytes goes out, repeat run opens
            seg1_in = 1'b1;
            hdr1_in = len_ff - LW'(3);
            cnt1_in = AW'(len_ff - LW'(2));
            len_in  = LW'(3);
            rep_in  = 1'b1;
         end else begin
            len_in = len_ff + 1'b1;
         end
      end else if (rep_ff && (len_ff < LW'(icnsrle24_pkg::REP_MAX))) begin
         if (match) begin
            len_in = len_ff + 1'b1;
         end else begin
            seg1_in   = 1'b1;
            tail1_in  = 1'b1;
            hdr1_in   = len_ff + LW'(icnsrle24_pkg::REP_BIAS);
            len_in    = LW'(1);
            rep_in    = 1'b0;
            wr_pos_in = '0;
         end
      end else begin
         // full run flushed, new literal opens
         seg1_in = 1'b1;
         if (rep_ff) begin
            tail1_in = 1'b1;
            hdr1_in  = len_ff + LW'(icnsrle24_pkg::REP_BIAS);
         end else begin
            hdr1_in = len_ff - 1'b1;
            cnt1_in = AW'(len_ff);
         end
         len_in    = LW'(1);
         rep_in    = 1'b0;
         wr_pos_in = '0;
      end
      if (rep_in) begin
         hdr2_in = len_in + LW'(icnsrle24_pkg::REP_BIAS);
         cnt2_in = '0;
      end else begin
         hdr2_in = len_in - 1'b1;
         cnt2_in = AW'(len_in - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         rep_ff <= 1'b0;
      end else if (cmd.take) begin
         len_ff <= req_data.end_of_channel ? '0 : len_in;
         rep_ff <= req_data.end_of_channel ? 1'b0 : rep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         p1_ff         <= b;
         p2_ff         <= p1_ff;
         seg1_ff       <= seg1_in;
         tail1_ff      <= tail1_in;
         eoc_ff        <= req_data.end_of_channel;
         wr_en_ff      <= !req_data.end_of_channel;
         cnt1_ff       <= cnt1_in;
         cnt2_ff       <= cnt2_in;
         wr_pos_ff     <= wr_pos_in;
         hdr1_ff       <= hdr1_in;
         hdr2_ff       <= hdr2_in;
         tail1_byte_ff <= p1_ff;
         b_ff          <= b;
      end
   end

   // run buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en_ff) begin
         mem[wr_pos_ff] <= b_ff;
      end
      if (ld && (cmd.src == icnsrle24_pkg::SRC_MEM)) begin
         mem_rd_ff <= mem[cmd.addr];
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign completes = s1_last_ff || (acc_cnt_ff == 3'd7);
   assign consume   = s1_valid_ff && (!completes || out_free);
   assign ld        = cmd.push && sts.byte_ready;
   assign cur_byte  = s1_mem_ff ? mem_rd_ff : s1_byte_ff;

   always_comb begin
      case (cmd.src)
         icnsrle24_pkg::SRC_HDR1:  s1_byte_in = hdr1_ff;
         icnsrle24_pkg::SRC_HDR2:  s1_byte_in = hdr2_ff;
         icnsrle24_pkg::SRC_TAIL1: s1_byte_in = tail1_byte_ff;
         icnsrle24_pkg::SRC_TAIL2: s1_byte_in = b_ff;
         default:                  s1_byte_in = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         merged[8*i +: 8] = (acc_cnt_ff == 3'(i)) ? cur_byte : acc_ff[8*i +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         s1_mem_ff  <= (cmd.src == icnsrle24_pkg::SRC_MEM);
         s1_byte_ff <= s1_byte_in;
         s1_last_ff <= cmd.last;
         s1_done_ff <= cmd.last && eoc_ff;
      end
      if (consume && completes) begin
         rsp_data_ff.code_bytes   <= merged;
         rsp_data_ff.byte_count   <= {1'b0, acc_cnt_ff} + 4'd1;
         rsp_data_ff.last_word    <= s1_last_ff;
         rsp_data_ff.channel_done <= s1_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         acc_cnt_ff   <= '0;
      end else begin
         if (ld) begin
            s1_valid_ff <= 1'b1;
         end else if (consume) begin
            s1_valid_ff <= 1'b0;
         end
         if (consume && completes) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (consume) begin
            if (completes) begin
               acc_ff     <= '0;
               acc_cnt_ff <= '0;
            end else begin
               acc_ff     <= merged;
               acc_cnt_ff <= acc_cnt_ff + 1'b1;
            end
         end
      end
   end

   assign sts.byte_ready = !s1_valid_ff || consume;
   assign sts.seg1       = seg1_ff;
   assign sts.tail1      = tail1_ff;
   assign sts.eoc        = eoc_ff;
   assign sts.cnt1       = cnt1_ff;
   assign sts.cnt2       = cnt2_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[tb/icns_rle24_channel_encoder_core_test.sv]
`timescale 1ns / 1ps
// self-checking bench for icns_rle24_channel_encoder_core: byte words in, code words out
// predicts packbits style rle24 code per accepted byte and checks every result word
// depends on icnsrle24_pkg and the encoder core rtl

module icns_rle24_channel_encoder_core_test;

   localparam int unsigned ITEM_GOAL = 460;
   localparam int unsigned DIR_ROWS  = 24;
   localparam int unsigned HOLD_SPAN = 400;  // long receiver hold-off, in cycles
   localparam int unsigned CODE_CAP  = 144;

   typedef struct {
      icnsrle24_pkg::req_type item;
      bit                     typed;   // expected word written out in the row
      icnsrle24_pkg::rsp_type want;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   icnsrle24_pkg::req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   icnsrle24_pkg::rsp_type rsp_data;

   // encoder state as the bench sees it
   logic [7:0]             run_mem [0:icnsrle24_pkg::RUN_DEPTH-1];
   int unsigned            run_len;
   bit                     rep_mode;
   logic [7:0]             code_buf [0:CODE_CAP-1];
   int unsigned            code_n;
   icnsrle24_pkg::rsp_type step_words[$];

   // code words still owed by the block, oldest first
   icnsrle24_pkg::rsp_type code_words_due[$];
   logic [7:0]             chan_q[$];
   int unsigned            bytes_taken;
   int unsigned            mismatches;

   icns_rle24_channel_encoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void put_code(input logic [7:0] v);
      code_buf[code_n] = v;
      code_n++;
   endfunction

   // write out whatever run is open
   function automatic void flush_open_run();
      int unsigned i;
      if (run_len == 0) return;
      if (rep_mode) begin
         put_code(8'(run_len + icnsrle24_pkg::REP_BIAS));
         put_code(run_mem[0]);
      end else begin
         put_code(8'(run_len - 1));
         for (i = 0; i < run_len; i++) put_code(run_mem[i]);
      end
   endfunction

   function automatic void open_literal(input logic [7:0] b);
      run_mem[0] = b;
      run_len    = 1;
      rep_mode   = 1'b0;
   endfunction

   // one input byte: update the run and build this byte's code words in step_words
   function automatic void encode_byte(input icnsrle24_pkg::req_type item);
      logic [7:0]             b;
      int unsigned            len;
      bit                     match;
      int unsigned            i;
      int unsigned            w;
      int unsigned            n_words;
      int unsigned            cnt;
      icnsrle24_pkg::rsp_type word;
      b      = item.channel_byte;
      len    = run_len;
      match  = 1'b0;
      code_n = 0;
      step_words.delete();
      if (len >= 2) match = (b == run_mem[len-1]) && (b == run_mem[len-2]);

      if (len == 0) begin
         open_literal(b);
      end else if (len < 2) begin
         run_mem[len] = b;
         run_len      = len + 1;
      end else if (len == 2) begin
         // third byte decides the run type
         rep_mode   = match;
         run_mem[2] = b;
         run_len    = 3;
      end else if (!rep_mode && len < icnsrle24_pkg::LIT_MAX) begin
         if (match) begin
            // literal part before the last two bytes goes out, the triple turns into a repeat
            put_code(8'(len - 3));
            for (i = 0; i < len - 2; i++) put_code(run_mem[i]);
            run_mem[0] = b;
            run_mem[1] = b;
            run_mem[2] = b;
            run_len    = 3;
            rep_mode   = 1'b1;
         end else begin
            run_mem[len] = b;
            run_len      = len + 1;
         end
      end else if (rep_mode && len < icnsrle24_pkg::REP_MAX) begin
         if (match) begin
            run_mem[len] = b;
            run_len      = len + 1;
         end else begin
            flush_open_run();
            open_literal(b);
         end
      end else begin
         // full run of either type: flush and restart with this byte
         flush_open_run();
         open_literal(b);
      end

      if (item.end_of_channel) begin
         flush_open_run();
         run_len  = 0;
         rep_mode = 1'b0;
      end

      // eight code bytes to a word, lowest lane first, nothing carried over
      n_words = (code_n + 7) / 8;
      for (w = 0; w < n_words; w++) begin
         word = '0;
         cnt  = (code_n - 8 * w > 8) ? 8 : code_n - 8 * w;
         for (i = 0; i < cnt; i++) word.code_bytes[8*i +: 8] = code_buf[8*w + i];
         word.byte_count   = 4'(cnt);
         word.last_word    = (w + 1 == n_words);
         word.channel_done = word.last_word && item.end_of_channel;
         step_words.push_back(word);
      end
   endfunction

   // ---------------------------------------------------------------- sender side

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 17) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 8);
      return $urandom_range(10, 30);
   endfunction

   // entered right after a falling edge, returns right after one
   task automatic offer_byte(input icnsrle24_pkg::req_type item, input int unsigned gap,
                             input bit typed, input icnsrle24_pkg::rsp_type want);
      int unsigned i;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      // word is taken on the first rising edge without stall
      do @(posedge clock); while (req_stall);
      encode_byte(item);
      if (typed) code_words_due.push_back(want);
      else for (i = 0; i < step_words.size(); i++) code_words_due.push_back(step_words[i]);
      bytes_taken++;
      @(negedge clock);
   endtask

   task automatic add_run(input logic [7:0] v, input int unsigned n);
      repeat (n) chan_q.push_back(v);
   endtask

   // no two neighbors equal, so nothing here turns into a repeat
   task automatic add_literal(input int unsigned n);
      logic [7:0] v;
      repeat (n) begin
         v = 8'($urandom_range(0, 255));
         if (chan_q.size() != 0 && v == chan_q[$]) v = v + 8'd1;
         chan_q.push_back(v);
      end
   endtask

   // send the queued channel, end-of-channel flag on its last byte
   task automatic send_channel(input bit burst);
      int unsigned            k;
      icnsrle24_pkg::req_type item;
      for (k = 0; k < chan_q.size(); k++) begin
         item.channel_byte   = chan_q[k];
         item.end_of_channel = (k + 1 == chan_q.size());
         offer_byte(item, burst ? 0 : pick_gap(), 1'b0, '0);
      end
      chan_q.delete();
   endtask

   function automatic dir_row_type plain_row(input logic [7:0] b, input logic eoc);
      dir_row_type r;
      r.item.channel_byte   = b;
      r.item.end_of_channel = eoc;
      r.typed               = 1'b0;
      r.want                = '0;
      return r;
   endfunction

   function automatic dir_row_type known_row(input logic [7:0] b, input logic eoc,
                                             input logic [63:0] code, input logic [3:0] cnt,
                                             input logic done);
      dir_row_type r;
      r                   = plain_row(b, eoc);
      r.typed             = 1'b1;
      r.want.code_bytes   = code;
      r.want.byte_count   = cnt;
      r.want.last_word    = 1'b1;
      r.want.channel_done = done;
      return r;
   endfunction

   initial begin : stimulus
      dir_row_type dir_rows [0:DIR_ROWS-1];
      int unsigned i;
      int unsigned segs;
      int unsigned pick;
      logic [7:0]  v;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      run_len     = 0;
      rep_mode    = 1'b0;
      bytes_taken = 0;
      mismatches  = 0;

      // single byte channels at both extremes
      dir_rows[0]  = known_row(8'h00, 1'b1, 64'h0000, 4'd2, 1'b1);
      dir_rows[1]  = known_row(8'hFF, 1'b1, 64'hFF00, 4'd2, 1'b1);
      // two byte literal
      dir_rows[2]  = plain_row(8'h3C, 1'b0);
      dir_rows[3]  = known_row(8'hC3, 1'b1, 64'hC33C01, 4'd3, 1'b1);
      // three equal bytes make a repeat of three
      dir_rows[4]  = plain_row(8'h55, 1'b0);
      dir_rows[5]  = plain_row(8'h55, 1'b0);
      dir_rows[6]  = known_row(8'h55, 1'b1, 64'h5580, 4'd2, 1'b1);
      // literal turned into a repeat, literal head goes out first
      dir_rows[7]  = plain_row(8'h10, 1'b0);
      dir_rows[8]  = plain_row(8'h20, 1'b0);
      dir_rows[9]  = plain_row(8'h20, 1'b0);
      dir_rows[10] = known_row(8'h20, 1'b0, 64'h1000, 4'd2, 1'b0);
      dir_rows[11] = known_row(8'h20, 1'b1, 64'h2081, 4'd2, 1'b1);
      // repeat broken by a different byte on the last byte
      dir_rows[12] = plain_row(8'h77, 1'b0);
      dir_rows[13] = plain_row(8'h77, 1'b0);
      dir_rows[14] = plain_row(8'h77, 1'b0);
      dir_rows[15] = known_row(8'h78, 1'b1, 64'h78007780, 4'd4, 1'b1);
      // third byte differs, stays literal, then a late triple
      dir_rows[16] = plain_row(8'h01, 1'b0);
      dir_rows[17] = plain_row(8'h02, 1'b0);
      dir_rows[18] = plain_row(8'h01, 1'b0);
      dir_rows[19] = plain_row(8'h01, 1'b0);
      dir_rows[20] = plain_row(8'h01, 1'b0);
      dir_rows[21] = plain_row(8'hFE, 1'b1);
      // a pair stays literal
      dir_rows[22] = plain_row(8'hAA, 1'b0);
      dir_rows[23] = plain_row(8'hAA, 1'b1);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         offer_byte(dir_rows[i].item, pick_gap(), dir_rows[i].typed, dir_rows[i].want);

      // full literal of 128, then a byte equal to the last two that must start afresh
      add_literal(127);
      add_run(chan_q[$], 3);
      send_channel(1'b0);

      // full repeat of 130, overrun by equal bytes, closed by a different one
      v = 8'($urandom_range(0, 255));
      add_run(v, $urandom_range(131, 135));
      add_run(v ^ 8'h5A, 1);
      send_channel(1'b1);

      // random channels built from runs, pairs, singles and noise
      while (bytes_taken < ITEM_GOAL) begin
         segs = $urandom_range(1, 4);
         repeat (segs) begin
            pick = $urandom_range(0, 29);
            if (pick < 16) begin
               // short run, sometimes continuing the previous value
               if (chan_q.size() != 0 && $urandom_range(0, 3) == 0) v = chan_q[$];
               else v = 8'($urandom_range(0, 255));
               add_run(v, $urandom_range(1, 5));
            end else if (pick < 22) begin
               add_run(8'($urandom_range(0, 255)), $urandom_range(6, 40));
            end else if (pick < 28) begin
               repeat ($urandom_range(1, 10)) chan_q.push_back(8'($urandom_range(0, 255)));
            end else if (bytes_taken + chan_q.size() + 150 < ITEM_GOAL) begin
               if (pick == 28) add_literal($urandom_range(118, 132));
               else add_run(8'($urandom_range(0, 255)), $urandom_range(125, 135));
            end else begin
               add_literal($urandom_range(2, 12));
            end
         end
         send_channel($urandom_range(0, 4) == 0);
      end
      req_valid <= 1'b0;

      // drain, then keep watching for any stray word
      while (code_words_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------- receiver side

   // random stall pattern; once, a long hold-off so the block backs up into its input
   initial begin : result_stall
      int unsigned span;
      int unsigned pick;
      bit          held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         if (!held && bytes_taken >= 80) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            span = HOLD_SPAN;
         end else begin
            pick = $urandom_range(0, 15);
            if (pick < 8) begin
               rsp_stall <= 1'b0;
               span = $urandom_range(1, 6);
            end else if (pick < 13) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(1, 3);
            end else if (pick < 15) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(10, 30);
            end else begin
               // free stretch with no stall at all
               rsp_stall <= 1'b0;
               span = $urandom_range(50, 200);
            end
         end
         repeat (span) @(negedge clock);
      end
   end

   // compare each accepted code word with the oldest one owed
   always @(posedge clock) begin : check_words
      icnsrle24_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (code_words_due.size() == 0) begin
            $error("code word with none owed: %h", rsp_data);
            mismatches++;
         end else begin
            want = code_words_due.pop_front();
            if (rsp_data.code_bytes !== want.code_bytes) begin
               $error("code_bytes: expected %h, got %h", want.code_bytes, rsp_data.code_bytes);
               mismatches++;
            end
            if (rsp_data.byte_count !== want.byte_count) begin
               $error("byte_count: expected %0d, got %0d", want.byte_count, rsp_data.byte_count);
               mismatches++;
            end
            if (rsp_data.last_word !== want.last_word) begin
               $error("last_word: expected %b, got %b", want.last_word, rsp_data.last_word);
               mismatches++;
            end
            if (rsp_data.channel_done !== want.channel_done) begin
               $error("channel_done: expected %b, got %b",
                      want.channel_done, rsp_data.channel_done);
               mismatches++;
            end
         end
      end
   end

   // hard stop well past the slowest correct run
   initial begin : run_limit
      #2_500_000;
      $display("status: fail");
      $finish;
   end

endmodule
